FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the trackball report block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/tmr_pkg.sv
// Types, codes and helper functions of the trackball motion to report block.
package tmr_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_LOCAL  = 2'd0,
        CMD_REMOTE = 2'd1,
        CMD_REPORT = 2'd2
    } t_cmd;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCROLL_DIV  = 2'd0;
    localparam logic [1:0] REG_LOCAL_BALL  = 2'd1;
    localparam logic [1:0] REG_REMOTE_BALL = 2'd2;

    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 3;
    localparam int AccW     = 16;
    localparam int RepW     = 8;

    localparam logic signed [AccW-1:0] AccMax  = 16'sh7FFF;
    localparam logic signed [AccW-1:0] AccMin  = -16'sh8000;
    localparam logic signed [AccW-1:0] ClipMax = 16'sd127;
    localparam logic signed [AccW-1:0] ClipMin = -16'sd127;

    typedef logic signed [AccW-1:0] t_acc;

    // One mouse report.
    typedef struct packed {
        logic signed [RepW-1:0] scroll_v;
        logic signed [RepW-1:0] scroll_h;
        logic signed [RepW-1:0] move_y;
        logic signed [RepW-1:0] move_x;
    } t_report;

    // Add two 16-bit values and stick at the signed limits.
    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        logic signed [AccW:0] sum;
        sum = 17'(a) + 17'(b);
        if (sum > 17'(AccMax)) begin
            return AccMax;
        end else if (sum < 17'(AccMin)) begin
            return AccMin;
        end
        return sum[AccW-1:0];
    endfunction

    // Clip to the symmetric report range.
    function automatic logic signed [RepW-1:0] clip127(input t_acc v);
        if (v > ClipMax) begin
            return ClipMax[RepW-1:0];
        end else if (v < ClipMin) begin
            return ClipMin[RepW-1:0];
        end
        return v[RepW-1:0];
    endfunction

endpackage

FILE: sv/trackball_motion_to_report.sv
// Top level: motion accumulators, report conversion and output skid buffer.
//
// Usage: motion and report requests arrive on the s_axis channel. tuser
// holds the command (local motion, remote motion, report request); tdata
// holds delta_x, delta_y and the scroll mode. Motion commands add into the
// matching saturating accumulator when that ball is present and give no
// output. A report request gives one transfer on m_axis carrying pointer
// and scroll values; pointer accumulators are cleared, scroll accumulators
// keep their remainder. The configuration port sets the scroll divisor and
// the two ball-present flags; the user must write it only while the block
// is idle, which the block itself does not enforce. Throughput: one item per
// cycle while s_axis_tready is high; the accumulator update and conversion
// finish in the cycle the item is taken, so the next item sees fresh state.
// When the receiver stalls, a two-entry output register (output stage plus
// skid stage) keeps accepting until both are full, then s_axis_tready drops.
// Reset (synchronous, active low) clears the accumulators, the
// configuration registers and both output stages.
`include "assert_macros.svh"

module trackball_motion_to_report #(
    parameter int DEFAULT_SCROLL_DIV = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [2:0]  i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // delta_x[15:0], delta_y[31:16], scroll_active[32]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // move_x[7:0], move_y[15:8], scroll_h[23:16],
                                       // scroll_v[31:24]
);

    localparam logic [2:0] DefShift = 3'(DEFAULT_SCROLL_DIV - 1);

    // Configuration registers.
    logic [2:0] r_scroll_div;
    logic       r_local_ball;
    logic       r_remote_ball;

    // Accumulators.
    tmr_pkg::t_acc r_local_x, r_local_y, r_remote_x, r_remote_y;
    tmr_pkg::t_acc n_local_x, n_local_y, n_remote_x, n_remote_y;

    // Output stage and skid stage.
    logic             r_out_valid, n_out_valid;
    tmr_pkg::t_report r_out_data, n_out_data;
    logic             r_skid_valid, n_skid_valid;
    tmr_pkg::t_report r_skid_data, n_skid_data;

    // Input fields.
    tmr_pkg::t_acc in_dx, in_dy;
    logic          in_scroll;
    logic          in_accept;
    logic          is_report;
    logic          remote_scroll;
    logic [2:0]    shift;
    tmr_pkg::t_acc rem_mask;
    tmr_pkg::t_report report;

    assign in_dx     = s_axis_tdata[15:0];
    assign in_dy     = s_axis_tdata[31:16];
    assign in_scroll = s_axis_tdata[32];

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_report     = (s_axis_tuser == tmr_pkg::CMD_REPORT);
    assign remote_scroll = in_scroll ^ r_local_ball;

    // Shift amount and the mask of the bits that a scroll report keeps.
    assign shift    = (r_scroll_div == 3'd0) ? DefShift : (r_scroll_div - 3'd1);
    assign rem_mask = tmr_pkg::t_acc'((16'd1 << shift) - 16'd1);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_div  <= 3'd0;
            r_local_ball  <= 1'b0;
            r_remote_ball <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tmr_pkg::REG_SCROLL_DIV:  r_scroll_div  <= i_cfg_data;
                tmr_pkg::REG_LOCAL_BALL:  r_local_ball  <= i_cfg_data[0];
                tmr_pkg::REG_REMOTE_BALL: r_remote_ball <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accumulator update and report conversion for one accepted item.
    always_comb begin
        n_local_x  = r_local_x;
        n_local_y  = r_local_y;
        n_remote_x = r_remote_x;
        n_remote_y = r_remote_y;
        report     = '0;
        if (in_accept) begin
            case (s_axis_tuser)
                tmr_pkg::CMD_LOCAL: begin
                    if (r_local_ball) begin
                        n_local_x = tmr_pkg::sat_add(r_local_x, in_dx);
                        n_local_y = tmr_pkg::sat_add(r_local_y, in_dy);
                    end
                end
                tmr_pkg::CMD_REMOTE: begin
                    if (r_remote_ball) begin
                        n_remote_x = tmr_pkg::sat_add(r_remote_x, in_dx);
                        n_remote_y = tmr_pkg::sat_add(r_remote_y, in_dy);
                    end
                end
                tmr_pkg::CMD_REPORT: begin
                    // The local ball first; the remote ball overrides its fields.
                    if (in_scroll) begin
                        report.scroll_h = tmr_pkg::clip127(r_local_x >>> shift);
                        report.scroll_v = tmr_pkg::clip127(r_local_y >>> shift);
                        n_local_x       = r_local_x & rem_mask;
                        n_local_y       = r_local_y & rem_mask;
                    end else begin
                        report.move_x = 8'(-tmr_pkg::clip127(r_local_x));
                        report.move_y = tmr_pkg::clip127(r_local_y);
                        n_local_x     = '0;
                        n_local_y     = '0;
                    end
                    if (remote_scroll) begin
                        report.scroll_h = tmr_pkg::clip127(r_remote_x >>> shift);
                        report.scroll_v = tmr_pkg::clip127(r_remote_y >>> shift);
                        n_remote_x      = r_remote_x & rem_mask;
                        n_remote_y      = r_remote_y & rem_mask;
                    end else begin
                        report.move_x = 8'(-tmr_pkg::clip127(r_remote_x));
                        report.move_y = tmr_pkg::clip127(r_remote_y);
                        n_remote_x    = '0;
                        n_remote_y    = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output and skid stages: a new report goes to the skid stage only while
    // the output stage is held by the receiver.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = in_accept && is_report;
                n_out_data  = report;
            end
        end else if (in_accept && is_report) begin
            n_skid_valid = 1'b1;
            n_skid_data  = report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_x    <= '0;
            r_local_y    <= '0;
            r_remote_x   <= '0;
            r_remote_y   <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_local_x    <= n_local_x;
            r_local_y    <= n_local_y;
            r_remote_x   <= n_remote_x;
            r_remote_y   <= n_remote_y;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The skid stage is only ever filled behind a full output stage.
    `ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)

    // An accepted report always leaves a result waiting at the output.
    `ASSERT_NEXT(a_report_gives_out, i_clk, i_rst_n,
        in_accept && is_report, r_out_valid)

    // A local ball reported as pointer motion starts again from zero.
    `ASSERT_NEXT(a_pointer_clears, i_clk, i_rst_n,
        in_accept && is_report && !in_scroll, r_local_x == '0 && r_local_y == '0)

    // Local motion without a local ball leaves the local accumulator alone.
    `ASSERT_NEXT(a_no_ball_holds, i_clk, i_rst_n,
        in_accept && s_axis_tuser == tmr_pkg::CMD_LOCAL && !r_local_ball,
        $stable(r_local_x) && $stable(r_local_y))

endmodule
